### rtl/u8sv_pkg.sv
// Shared types and constants of the UTF-8 stream validator.
`default_nettype none
package u8sv_pkg;

	// Error kinds reported with a verdict.
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_NUL       = 3'd1;
	localparam logic [2:0] ERR_BAD_LEAD  = 3'd2;
	localparam logic [2:0] ERR_FIRST_CONT = 3'd3;
	localparam logic [2:0] ERR_BAD_CONT  = 3'd4;
	localparam logic [2:0] ERR_TRUNCATED = 3'd5;
	localparam logic [2:0] ERR_EMPTY     = 3'd6;

	// Byte values that bound the lead and continuation ranges.
	localparam logic [7:0] CONT_LOW      = 8'h80;
	localparam logic [7:0] CONT_HIGH     = 8'hBF;
	localparam logic [7:0] LEAD2_MIN     = 8'hC2;
	localparam logic [7:0] LEAD3_OVERLONG = 8'hE0;
	localparam logic [7:0] LEAD3_SURR    = 8'hED;
	localparam logic [7:0] LEAD4_OVERLONG = 8'hF0;
	localparam logic [7:0] LEAD4_MAX     = 8'hF4;
	localparam logic [7:0] E0_CONT_LOW   = 8'hA0;
	localparam logic [7:0] ED_CONT_HIGH  = 8'h9F;
	localparam logic [7:0] F0_CONT_LOW   = 8'h90;
	localparam logic [7:0] F4_CONT_HIGH  = 8'h8F;

	// Per-string tracking state.
	typedef struct packed {
		logic [1:0] pend;
		logic       first;
		logic [7:0] lo;
		logic [7:0] hi;
		logic       err;
		logic [2:0] kind;
	} u8sv_state_t;

	localparam u8sv_state_t STATE_RESET = '{
		pend: 2'd0, first: 1'b0, lo: CONT_LOW, hi: CONT_HIGH,
		err: 1'b0, kind: ERR_NONE
	};

	// Outcome of one byte: whether it ends a string, and the verdict.
	typedef struct packed {
		logic       vld;
		logic       ok;
		logic [2:0] kind;
	} u8sv_result_t;

endpackage
`default_nettype wire

### rtl/u8sv_if.sv
// Channel interfaces of the UTF-8 stream validator: bytes in, verdicts out, configuration.
`default_nettype none
interface u8sv_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       last_byte;
	logic       empty_string;
	modport source (output valid, output text_byte, output last_byte, output empty_string,
		input ready);
	modport sink (input valid, input text_byte, input last_byte, input empty_string,
		output ready);
endinterface

interface u8sv_verdict_if;
	logic       valid;
	logic       ready;
	logic       string_valid;
	logic [2:0] error_kind;
	modport source (output valid, output string_valid, output error_kind, input ready);
	modport sink (input valid, input string_valid, input error_kind, output ready);
endinterface

interface u8sv_cfg_if;
	logic valid;
	logic ready;
	logic reject_empty;
	modport source (output valid, output reject_empty, input ready);
	modport sink (input valid, input reject_empty, output ready);
endinterface
`default_nettype wire

### rtl/u8sv_step.sv
// Per-byte decision logic: next tracking state and verdict for one beat.
`default_nettype none
module u8sv_step (
	input  wire u8sv_pkg::u8sv_state_t  st,
	input  wire logic [7:0]             text_byte,
	input  wire logic                   last_byte,
	input  wire logic                   empty_string,
	input  wire logic                   reject_empty,
	output u8sv_pkg::u8sv_state_t       st_next,
	output u8sv_pkg::u8sv_result_t      res
);
	import u8sv_pkg::*;

	u8sv_state_t tb;
	logic [7:0]  c;

	assign c = text_byte;

	// Effect of the byte itself on the tracking state.
	always_comb begin
		tb = st;
		if (!st.err) begin
			if (st.pend != 2'd0) begin
				if (st.first) begin
					if (c < st.lo || c > st.hi) begin
						tb.err  = 1'b1;
						tb.kind = ERR_FIRST_CONT;
					end else begin
						tb.first = 1'b0;
						tb.pend  = st.pend - 2'd1;
					end
				end else if (c[7:6] != 2'b10) begin
					tb.err  = 1'b1;
					tb.kind = ERR_BAD_CONT;
				end else begin
					tb.pend = st.pend - 2'd1;
				end
			end else if (c == 8'h00) begin
				tb.err  = 1'b1;
				tb.kind = ERR_NUL;
			end else if (c[7]) begin
				tb.lo    = CONT_LOW;
				tb.hi    = CONT_HIGH;
				tb.first = 1'b1;
				if (c inside {[LEAD2_MIN:8'hDF]}) begin
					tb.pend = 2'd1;
				end else if (c inside {[LEAD3_OVERLONG:8'hEF]}) begin
					tb.pend = 2'd2;
					if (c == LEAD3_OVERLONG) tb.lo = E0_CONT_LOW;
					if (c == LEAD3_SURR) tb.hi = ED_CONT_HIGH;
				end else if (c inside {[LEAD4_OVERLONG:LEAD4_MAX]}) begin
					tb.pend = 2'd3;
					if (c == LEAD4_OVERLONG) tb.lo = F0_CONT_LOW;
					if (c == LEAD4_MAX) tb.hi = F4_CONT_HIGH;
				end else begin
					tb.first = st.first;
					tb.err   = 1'b1;
					tb.kind  = ERR_BAD_LEAD;
				end
			end
		end
	end

	// End of string: empty marker, or the last byte with truncation check.
	always_comb begin
		st_next  = tb;
		res.vld  = 1'b0;
		res.ok   = 1'b0;
		res.kind = ERR_NONE;
		if (empty_string) begin
			st_next  = STATE_RESET;
			res.vld  = 1'b1;
			res.ok   = !reject_empty;
			res.kind = reject_empty ? ERR_EMPTY : ERR_NONE;
		end else if (last_byte) begin
			st_next = STATE_RESET;
			res.vld = 1'b1;
			if (tb.err) begin
				res.kind = tb.kind;
			end else if (tb.pend != 2'd0) begin
				res.kind = ERR_TRUNCATED;
			end else begin
				res.ok = 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/utf8_stream_validator.sv
// Top level of the UTF-8 stream validator: input register, byte decision, verdict register.
// Usage:
// The text channel carries one string byte per beat, with last_byte set on the final
// byte, or a single beat with empty_string set for a string that has no bytes.
// The verdict channel returns one beat per string: string_valid, and error_kind naming
// the first error found (NUL, bad lead, first continuation out of range, bad
// continuation, truncated sequence, or empty string). Beats that do not end a string
// produce nothing on the verdict channel.
// The cfg channel writes reject_empty, which is always ready; write it only while no
// string is in flight. Reset sets reject_empty to 1.
// Timing: each byte is registered on acceptance, decided in the following cycle by the
// per-byte logic, and a string-ending byte then loads the verdict register, which drives
// the verdict channel. One byte is taken every cycle while no string-ending byte is
// stalled in the input register.
// Stalls: when the verdict register is full and the receiver holds ready low, bytes
// that end no string keep flowing; only a string-ending byte waits in the input
// register, and text.ready drops until the verdict is taken.
// Reset (arst_n low) empties both registers, clears the per-string state and drops all
// partial strings.
`default_nettype none
module utf8_stream_validator (
	input  wire logic  clk,
	input  wire logic  arst_n,
	u8sv_text_if.sink      text,
	u8sv_verdict_if.source verdict,
	u8sv_cfg_if.sink       cfg
);
	import u8sv_pkg::*;

	logic         reject_empty_q;
	logic         vld_s1;
	logic [7:0]   text_byte_s1;
	logic         last_byte_s1;
	logic         empty_string_s1;
	u8sv_state_t  st_q;
	u8sv_state_t  st_next;
	u8sv_result_t res;
	logic         out_vld_q;
	logic         out_ok_q;
	logic [2:0]   out_kind_q;
	logic         adv_s1;

	// The configuration register takes every write at once.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reject_empty_q <= 1'b1;
		end else if (cfg.valid) begin
			reject_empty_q <= cfg.reject_empty;
		end
	end

	// The byte in stage one may move on unless it ends a string and the verdict
	// register still holds a beat the receiver has not taken.
	assign adv_s1     = vld_s1 && (!res.vld || !out_vld_q || verdict.ready);
	assign text.ready = !vld_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (text.ready) begin
			vld_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			text_byte_s1    <= text.text_byte;
			last_byte_s1    <= text.last_byte;
			empty_string_s1 <= text.empty_string;
		end
	end

	u8sv_step u_step (
		.st           (st_q),
		.text_byte    (text_byte_s1),
		.last_byte    (last_byte_s1),
		.empty_string (empty_string_s1),
		.reject_empty (reject_empty_q),
		.st_next      (st_next),
		.res          (res)
	);

	// The per-string state moves only when the byte in stage one is consumed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_RESET;
		end else if (adv_s1) begin
			st_q <= st_next;
		end
	end

	// Verdict register: loaded by a string-ending byte, emptied when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv_s1 && res.vld) begin
			out_vld_q <= 1'b1;
		end else if (verdict.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && res.vld) begin
			out_ok_q   <= res.ok;
			out_kind_q <= res.kind;
		end
	end

	assign verdict.valid        = out_vld_q;
	assign verdict.string_valid = out_ok_q;
	assign verdict.error_kind   = out_kind_q;

	// A clear error flag always goes with no recorded kind, and a set one with a kind.
	a_err_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.err == (st_q.kind != ERR_NONE)))
		else $error("error flag and recorded kind disagree");

	// The first-continuation flag is only meaningful while continuations are owed.
	a_first_pend: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.first |-> (st_q.pend != 2'd0))
		else $error("first continuation flagged with nothing owed");

	// A valid verdict never carries an error kind.
	a_ok_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_ok_q) |-> (out_kind_q == ERR_NONE))
		else $error("valid verdict with an error kind");

	// A byte held in stage one keeps its contents until it moves on.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !adv_s1) |=> (vld_s1 && $stable(text_byte_s1)
			&& $stable(last_byte_s1) && $stable(empty_string_s1)))
		else $error("stalled stage-one byte changed");

	// A verdict register that is full and not taken is not overwritten.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !verdict.ready) |=> (out_vld_q && $stable(out_ok_q)
			&& $stable(out_kind_q)))
		else $error("pending verdict overwritten");

endmodule
`default_nettype wire
